// ----- src/pdc_pkg.sv -----
// Shared types, constants and helper functions of the Playfair digraph cipher.
package pdc_pkg;

    localparam int SYM_W  = 8;
    localparam int LET_W  = 5;
    localparam int OUT_W  = 7;
    localparam int ROW_W  = 3;
    localparam int SIDE   = 5;
    localparam int CELLS  = 25;
    localparam int ALPHA  = 26;

    localparam logic [LET_W-1:0] IDX_I    = LET_W'(8);
    localparam logic [LET_W-1:0] IDX_J    = LET_W'(9);
    localparam logic [LET_W-1:0] IDX_X    = LET_W'(23);
    localparam logic [LET_W-1:0] IDX_LAST = LET_W'(ALPHA - 1);
    localparam logic [LET_W-1:0] FILL_MAX = LET_W'(CELLS);

    localparam logic [SYM_W-1:0] ASCII_LA = 8'h61;
    localparam logic [SYM_W-1:0] ASCII_LZ = 8'h7a;
    localparam logic [SYM_W-1:0] ASCII_UA = 8'h41;
    localparam logic [SYM_W-1:0] ASCII_UZ = 8'h5a;
    localparam logic [OUT_W-1:0] ASCII_A7 = 7'h61;

    localparam logic [ALPHA-1:0] TAKEN_RST = ALPHA'(1) << IDX_J;

    typedef enum logic [1:0] {
        MODE_KEY      = 2'd0,
        MODE_KEY_DONE = 2'd1,
        MODE_TEXT     = 2'd2,
        MODE_TEXT_END = 2'd3
    } t_mode;

    // Controller to datapath commands
    typedef struct packed {
        logic place_in;    // place the input letter in the square
        logic place_walk;  // place the walk letter in the square
        logic walk_clr;
        logic walk_inc;
        logic hold_load;   // hold the mapped input letter
        logic hold_clear;
        logic pair_ld;     // load pair: held letter and (x or input letter)
        logic pair_b_x;
        logic rd_pa;       // read position of first letter
        logic rd_pb;       // read position of second letter, capture first
        logic cell_ld;     // compute both output cells
        logic rd_s0;
        logic rd_s1;       // read second cell, capture first letter
        logic ob_load;     // move the finished pair into the output buffer
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_letter;
        logic in_taken;
        logic held_valid;
        logic held_match;
        logic dir;
        logic walk_taken;
        logic walk_last;
        logic ob_empty;
    } t_stat;

    // Row of a cell: p * 13 >> 6 equals p / 5 for p below 25
    function automatic logic [ROW_W-1:0] f_row(input logic [LET_W-1:0] p);
        logic [9:0] t;
        t = 10'(p) * 10'd13;
        return t[8:6];
    endfunction

    function automatic logic [ROW_W-1:0] f_col(input logic [LET_W-1:0] p);
        logic [ROW_W-1:0] r;
        logic [LET_W-1:0] t;
        r = f_row(p);
        t = p - (LET_W'(r) << 2) - LET_W'(r);
        return t[ROW_W-1:0];
    endfunction

    // Advance a row or column by one (encrypt) or four (decrypt), modulo 5
    function automatic logic [ROW_W-1:0] f_step(input logic [ROW_W-1:0] v, input logic dir);
        logic [ROW_W:0] t;
        t = {1'b0, v} + (dir ? 4'd4 : 4'd1);
        if (t >= 4'(SIDE)) begin
            t = t - 4'(SIDE);
        end
        return t[ROW_W-1:0];
    endfunction

    function automatic logic [LET_W-1:0] f_cell(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] c);
        return (LET_W'(r) << 2) + LET_W'(r) + LET_W'(c);
    endfunction

endpackage

// ----- src/pdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/pdc_ctrl.sv -----
// Controller state machine: item decode, key fill walk and pair sequencing.
module pdc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pdc_pkg::t_mode  i_mode,
    input  pdc_pkg::t_stat  i_stat,
    output pdc_pkg::t_cmd   o_cmd
);
    import pdc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_FILL = 8'b0000_0010,
        S_PA   = 8'b0000_0100,
        S_PB   = 8'b0000_1000,
        S_CELL = 8'b0001_0000,
        S_S0   = 8'b0010_0000,
        S_S1   = 8'b0100_0000,
        S_WAIT = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode)
                        MODE_KEY: begin
                            cmd.place_in = i_stat.in_letter & ~i_stat.in_taken;
                        end
                        MODE_KEY_DONE: begin
                            cmd.walk_clr = 1'b1;
                            n_state      = S_FILL;
                        end
                        MODE_TEXT: begin
                            if (i_stat.in_letter) begin
                                if (!i_stat.held_valid) begin
                                    cmd.hold_load = 1'b1;
                                end else begin
                                    cmd.pair_ld = 1'b1;
                                    // doubled letter: pad with x, keep the new one held
                                    if (!i_stat.dir && i_stat.held_match) begin
                                        cmd.pair_b_x = 1'b1;
                                    end else begin
                                        cmd.hold_clear = 1'b1;
                                    end
                                    n_state = S_PA;
                                end
                            end
                        end
                        MODE_TEXT_END: begin
                            if (i_stat.held_valid) begin
                                cmd.hold_clear = 1'b1;
                                if (!i_stat.dir) begin
                                    cmd.pair_ld  = 1'b1;
                                    cmd.pair_b_x = 1'b1;
                                    n_state      = S_PA;
                                end
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                cmd.place_walk = ~i_stat.walk_taken;
                cmd.walk_inc   = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_PA: begin
                cmd.rd_pa = 1'b1;
                n_state   = S_PB;
            end
            S_PB: begin
                cmd.rd_pb = 1'b1;
                n_state   = S_CELL;
            end
            S_CELL: begin
                cmd.cell_ld = 1'b1;
                n_state     = S_S0;
            end
            S_S0: begin
                cmd.rd_s0 = 1'b1;
                n_state   = S_S1;
            end
            S_S1: begin
                cmd.rd_s1 = 1'b1;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                // hold until the previous pair has left the output buffer
                if (i_stat.ob_empty) begin
                    cmd.ob_load = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

// ----- src/pdc_dpath.sv -----
// Datapath: key square and position RAMs, letter state, cell math, output buffer.
module pdc_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pdc_pkg::t_cmd               i_cmd,
    output pdc_pkg::t_stat              o_stat,
    input  logic [pdc_pkg::SYM_W-1:0]   i_symbol,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [pdc_pkg::OUT_W-1:0]   o_letter,
    output logic                        o_pair_last
);
    import pdc_pkg::*;

    logic [LET_W-1:0] r_fill;
    logic [LET_W-1:0] r_walk;
    logic [LET_W-1:0] r_held;
    logic             r_held_valid;
    logic [ALPHA-1:0] r_taken;
    logic             r_dir;
    logic [1:0]       r_ob_cnt;

    logic [LET_W-1:0] r_a;
    logic [LET_W-1:0] r_b;
    logic [LET_W-1:0] r_pa;
    logic [LET_W-1:0] r_c0;
    logic [LET_W-1:0] r_c1;
    logic [LET_W-1:0] r_l0;
    logic [LET_W-1:0] r_ob_l0;
    logic [LET_W-1:0] r_ob_l1;

    logic             in_lower;
    logic             in_upper;
    logic             in_letter;
    logic [SYM_W-1:0] in_diff;
    logic [LET_W-1:0] in_idx;
    logic [LET_W-1:0] in_map;

    logic             place_en;
    logic [LET_W-1:0] place_idx;
    logic             sq_wr_en;
    logic [LET_W-1:0] pos_rd_data;
    logic [LET_W-1:0] sq_rd_data;

    logic [ROW_W-1:0] ra, ca, rb, cb;
    logic [LET_W-1:0] c0, c1;
    logic             out_fire;
    logic [LET_W-1:0] ob_sel;

    // Letter decode of the input byte
    assign in_lower  = (i_symbol >= ASCII_LA) && (i_symbol <= ASCII_LZ);
    assign in_upper  = (i_symbol >= ASCII_UA) && (i_symbol <= ASCII_UZ);
    assign in_letter = in_lower | in_upper;
    assign in_diff   = i_symbol - (in_lower ? ASCII_LA : ASCII_UA);
    assign in_idx    = in_diff[LET_W-1:0];
    assign in_map    = (in_idx == IDX_J) ? IDX_I : in_idx;

    assign place_en  = i_cmd.place_in | i_cmd.place_walk;
    assign place_idx = i_cmd.place_in ? in_idx : r_walk;
    assign sq_wr_en  = place_en && (r_fill < FILL_MAX);

    pdc_ram #(.WIDTH(LET_W), .DEPTH(ALPHA)) u_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sq_wr_en),
        .i_wr_addr (place_idx),
        .i_wr_data (r_fill),
        .i_rd_en   (i_cmd.rd_pa | i_cmd.rd_pb),
        .i_rd_addr (i_cmd.rd_pa ? r_a : r_b),
        .o_rd_data (pos_rd_data)
    );

    pdc_ram #(.WIDTH(LET_W), .DEPTH(CELLS)) u_sq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sq_wr_en),
        .i_wr_addr (r_fill),
        .i_wr_data (place_idx),
        .i_rd_en   (i_cmd.rd_s0 | i_cmd.rd_s1),
        .i_rd_addr (i_cmd.rd_s0 ? r_c0 : r_c1),
        .o_rd_data (sq_rd_data)
    );

    // Row, column or rectangle rule on the two positions
    always_comb begin
        ra = f_row(r_pa);
        ca = f_col(r_pa);
        rb = f_row(pos_rd_data);
        cb = f_col(pos_rd_data);
        if (ra == rb) begin
            c0 = f_cell(ra, f_step(ca, r_dir));
            c1 = f_cell(rb, f_step(cb, r_dir));
        end else if (ca == cb) begin
            c0 = f_cell(f_step(ra, r_dir), ca);
            c1 = f_cell(f_step(rb, r_dir), cb);
        end else begin
            c0 = f_cell(ra, cb);
            c1 = f_cell(rb, ca);
        end
    end

    assign out_fire = o_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_walk       <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_taken      <= TAKEN_RST;
            r_dir        <= 1'b0;
            r_ob_cnt     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_dir <= i_cfg_data;
            end
            if (sq_wr_en) begin
                r_fill <= r_fill + 1'b1;
            end
            if (place_en) begin
                r_taken[place_idx] <= 1'b1;
            end
            if (i_cmd.walk_clr) begin
                r_walk <= '0;
            end else if (i_cmd.walk_inc) begin
                r_walk <= r_walk + 1'b1;
            end
            if (i_cmd.hold_load || (i_cmd.pair_ld && i_cmd.pair_b_x && !i_cmd.hold_clear)) begin
                r_held       <= in_map;
                r_held_valid <= 1'b1;
            end else if (i_cmd.hold_clear) begin
                r_held_valid <= 1'b0;
            end
            if (i_cmd.ob_load) begin
                r_ob_cnt <= 2'd2;
            end else if (out_fire) begin
                r_ob_cnt <= r_ob_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_ld) begin
            r_a <= r_held;
            r_b <= i_cmd.pair_b_x ? IDX_X : in_map;
        end
        if (i_cmd.rd_pb) begin
            r_pa <= pos_rd_data;
        end
        if (i_cmd.cell_ld) begin
            r_c0 <= c0;
            r_c1 <= c1;
        end
        if (i_cmd.rd_s1) begin
            r_l0 <= sq_rd_data;
        end
        if (i_cmd.ob_load) begin
            r_ob_l0 <= r_l0;
            r_ob_l1 <= sq_rd_data;
        end
    end

    assign ob_sel      = (r_ob_cnt == 2'd2) ? r_ob_l0 : r_ob_l1;
    assign o_out_valid = (r_ob_cnt != 2'd0);
    assign o_letter    = ASCII_A7 + OUT_W'(ob_sel);
    assign o_pair_last = (r_ob_cnt == 2'd1);

    always_comb begin
        o_stat            = '0;
        o_stat.in_letter  = in_letter;
        o_stat.in_taken   = r_taken[in_idx];
        o_stat.held_valid = r_held_valid;
        o_stat.held_match = (r_held == in_map);
        o_stat.dir        = r_dir;
        o_stat.walk_taken = r_taken[r_walk];
        o_stat.walk_last  = (r_walk == IDX_LAST);
        o_stat.ob_empty   = (r_ob_cnt == 2'd0);
    end

endmodule

// ----- src/playfair_digraph_cipher_top.sv -----
// Top level of the Playfair digraph cipher: stream ports, controller and datapath.
// Key finished starts a walk over the alphabet. A pair passes the states PA, PB, CELL, S0, S1
// and WAIT from accept until the block accepts again, set by the two position reads and
// two square reads through the single read port of each RAM; WAIT holds while the output
// buffer is still full. The two letters of a pair then leave over 2 transactions.
// Reset clears the control state and marks only j as taken; square contents follow the key.
module playfair_digraph_cipher_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic [1:0] s_axis_tuser,   // [1:0] mode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] letter, [7] zero
    output logic       m_axis_tlast,   // pair_last
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data      // direction
);
    import pdc_pkg::*;

    t_cmd             cmd;
    t_stat            stat;
    logic [OUT_W-1:0] letter;

    pdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_mode     (t_mode'(s_axis_tuser)),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pdc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_symbol    (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_letter    (letter),
        .o_pair_last (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, letter};
    assign o_cfg_ready  = 1'b1;

endmodule

// ----- tb/cipher_letter_checker.sv -----
// Checker for the Playfair cipher streams: tracks the key square, predicts and compares letters.
module cipher_letter_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_symbol,   // [7:0] symbol
    input  logic [1:0] i_in_mode,     // [1:0] mode
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,    // [6:0] letter, [7] zero
    input  logic       i_out_last,    // pair_last
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_data,    // direction
    output int         o_fail_count,
    output int         o_letters_due
);
    import pdc_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] letter;
        logic             last;
    } t_cipher_letter;

    logic [LET_W-1:0] grid [CELLS];
    logic [LET_W-1:0] grid_cell_of [ALPHA];
    logic [ALPHA-1:0] used;
    int               grid_fill;
    logic [LET_W-1:0] held;
    logic             held_ok;
    logic             decrypt;
    t_cipher_letter   letters_due [$];
    t_cipher_letter   got_due;
    int               fails = 0;

    function automatic int to_letter(logic [7:0] s);
        if (s >= ASCII_LA && s <= ASCII_LZ) begin
            return int'(s - ASCII_LA);
        end
        if (s >= ASCII_UA && s <= ASCII_UZ) begin
            return int'(s - ASCII_UA);
        end
        return -1;
    endfunction

    task automatic report(string field, int want, int got);
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        fails++;
    endtask

    task automatic add_to_grid(int idx);
        if (grid_fill < CELLS) begin
            grid[grid_fill]   = LET_W'(idx);
            grid_cell_of[idx] = LET_W'(grid_fill);
            grid_fill++;
        end
        used[idx] = 1'b1;
    endtask

    task automatic encode_pair(logic [LET_W-1:0] a, logic [LET_W-1:0] b);
        int             pa, pb, ra, ca, rb, cb, sh, c0, c1;
        t_cipher_letter first, second;
        pa = int'(grid_cell_of[a]);
        pb = int'(grid_cell_of[b]);
        ra = pa / SIDE;
        ca = pa % SIDE;
        rb = pb / SIDE;
        cb = pb % SIDE;
        sh = decrypt ? 4 : 1;
        if (ra == rb) begin
            c0 = ra * SIDE + (ca + sh) % SIDE;
            c1 = rb * SIDE + (cb + sh) % SIDE;
        end else if (ca == cb) begin
            c0 = ((ra + sh) % SIDE) * SIDE + ca;
            c1 = ((rb + sh) % SIDE) * SIDE + cb;
        end else begin
            // rectangle: swap the columns
            c0 = ra * SIDE + cb;
            c1 = rb * SIDE + ca;
        end
        first.letter  = ASCII_A7 + OUT_W'(grid[c0]);
        first.last    = 1'b0;
        second.letter = ASCII_A7 + OUT_W'(grid[c1]);
        second.last   = 1'b1;
        letters_due.push_back(first);
        letters_due.push_back(second);
    endtask

    task automatic cipher_step(t_mode m, logic [7:0] sym);
        int idx, i;
        idx = to_letter(sym);
        case (m)
            MODE_KEY: begin
                if (idx >= 0 && !used[idx]) begin
                    add_to_grid(idx);
                end
            end
            MODE_KEY_DONE: begin
                for (i = 0; i < ALPHA; i++) begin
                    if (!used[i]) begin
                        add_to_grid(i);
                    end
                end
            end
            MODE_TEXT: begin
                if (idx >= 0) begin
                    if (idx == int'(IDX_J)) begin
                        idx = int'(IDX_I);
                    end
                    if (!held_ok) begin
                        held    = LET_W'(idx);
                        held_ok = 1'b1;
                    end else if (!decrypt && held == LET_W'(idx)) begin
                        // doubled letter: pad with x, keep the new one held
                        encode_pair(held, IDX_X);
                    end else begin
                        held_ok = 1'b0;
                        encode_pair(held, LET_W'(idx));
                    end
                end
            end
            default: begin
                if (held_ok) begin
                    held_ok = 1'b0;
                    if (!decrypt) begin
                        encode_pair(held, IDX_X);
                    end
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                grid[i] = '0;
            end
            for (int i = 0; i < ALPHA; i++) begin
                grid_cell_of[i] = '0;
            end
            used      = TAKEN_RST;
            grid_fill = 0;
            held      = '0;
            held_ok   = 1'b0;
            decrypt   = 1'b0;
            letters_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (letters_due.size() == 0) begin
                    report("unexpected letter", -1, int'(i_out_data[OUT_W-1:0]));
                end else begin
                    got_due = letters_due.pop_front();
                    if (i_out_data[OUT_W-1:0] !== got_due.letter) begin
                        report("letter", int'(got_due.letter), int'(i_out_data[OUT_W-1:0]));
                    end
                    if (i_out_last !== got_due.last) begin
                        report("pair_last", int'(got_due.last), int'(i_out_last));
                    end
                    if (i_out_data[7] !== 1'b0) begin
                        report("tdata pad bit", 0, int'(i_out_data[7]));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                decrypt = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                cipher_step(t_mode'(i_in_mode), i_in_symbol);
            end
        end
        o_fail_count  <= fails;
        o_letters_due <= letters_due.size();
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the Playfair cipher: clock, reset, key and text stimulus, verdict.
module tb;
    import pdc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 190;
    localparam int SETTLE      = 40;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;

    int fail_count;
    int due_count;
    int cycles = 0;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;
    int stall_left = 0;
    int stall_pick;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    playfair_digraph_cipher_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    cipher_letter_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_symbol   (s_axis_tdata),
        .i_in_mode     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_last    (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_letters_due (due_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: mostly short stalls, now and then a long one
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!out_calm) begin
                stall_pick = $urandom_range(0, 99);
                if (stall_pick < 25) begin
                    stall_left = $urandom_range(1, 3);
                end else if (stall_pick < 28) begin
                    stall_left = $urandom_range(15, 40);
                end
            end
        end
    end

    function automatic logic [7:0] letter_byte(int idx);
        return ($urandom_range(0, 1) ? ASCII_UA : ASCII_LA) + 8'(idx);
    endfunction

    task automatic send_item(t_mode m, logic [7:0] sym);
        int gap, pick;
        pick = $urandom_range(0, 99);
        if (in_calm || pick < 50) begin
            gap = 0;
        end else if (pick < 85) begin
            gap = $urandom_range(1, 3);
        end else if (pick < 97) begin
            gap = $urandom_range(4, 10);
        end else begin
            gap = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tuser  <= m;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_string(t_mode m, string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(m, s[i]);
        end
    endtask

    // Drop valid and hold until every predicted letter has come out
    task automatic settle(int pause);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_count != 0) @(posedge i_clk);
        repeat (pause) @(posedge i_clk);
    endtask

    task automatic write_direction(logic dir);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= dir;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int n, pick, idx, prev, key_len;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_direction(1'b0);

        // Key: case folding, j and repeats dropped, bytes around the letter ranges
        send_string(MODE_KEY, "PlAyjJ@[`{Zzpa");
        send_item(MODE_KEY, 8'h00);
        send_item(MODE_KEY, 8'hff);
        key_len = $urandom_range(0, 30);
        for (int k = 0; k < key_len; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                send_item(MODE_KEY, letter_byte($urandom_range(0, 25)));
            end else begin
                send_item(MODE_KEY, 8'($urandom));
            end
        end
        send_item(MODE_KEY_DONE, 8'($urandom));
        // key after the square is full: ignored
        send_item(MODE_KEY, "q");
        send_item(MODE_KEY_DONE, 8'($urandom));

        // Encrypt: doubled letters, x x, j folded to i, dropped bytes, padding
        send_string(MODE_TEXT, "AzHelloXxJi5");
        send_item(MODE_TEXT, 8'h80);
        send_item(MODE_TEXT_END, 8'h00);
        send_item(MODE_TEXT_END, 8'hff);
        settle(SETTLE);

        // Decrypt: lone trailing letter dropped, doubled pair kept whole
        write_direction(1'b1);
        send_string(MODE_TEXT, "bZd");
        send_item(MODE_TEXT_END, 8'h00);
        send_string(MODE_TEXT, "Dd");
        send_item(MODE_TEXT, 8'hff);
        settle(SETTLE);

        prev = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_direction(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    if ($urandom_range(0, 3) == 0) begin
                        idx = prev;
                    end else if ($urandom_range(0, 9) == 0) begin
                        idx = int'(IDX_X);
                    end else begin
                        idx = $urandom_range(0, 25);
                    end
                    prev = idx;
                    send_item(MODE_TEXT, letter_byte(idx));
                    n++;
                end else if (pick < 80) begin
                    send_item(MODE_TEXT, 8'($urandom));
                    n++;
                end else if (pick < 88) begin
                    send_item(MODE_TEXT_END, 8'($urandom));
                    n++;
                end else if (pick < 93) begin
                    send_item(MODE_KEY, 8'($urandom));
                    n++;
                end else if (pick < 96) begin
                    send_item(MODE_KEY_DONE, 8'($urandom));
                    n++;
                end else begin
                    settle(0);
                end
            end
            // now and then flush a held letter before the direction change, else leave it held across it
            if ($urandom_range(0, 1) == 1) begin
                send_item(MODE_TEXT_END, 8'($urandom));
            end
            settle(SETTLE);
        end

        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/pdc_pkg.sv
src/pdc_ram.sv
src/pdc_ctrl.sv
src/pdc_dpath.sv
src/playfair_digraph_cipher_top.sv
tb/cipher_letter_checker.sv
tb/tb.sv
